// ===== rtl/mwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwm_pkg: shared types and constants for the mecanum wheel mixer
// Payload structs, pipeline lane types and the output saturation function.
// ----------------------------------------------------------------------------
package mwm_pkg;

    localparam int SPEED_WIDTH = 16;
    localparam int NUM_WHEELS  = 4;
    localparam int MAX_W       = 15;
    // |vx +- vy +- vw| <= 3 * 2^(SPEED_WIDTH-1)
    localparam int MAG_W       = SPEED_WIDTH + 1;
    localparam int SUM_W       = SPEED_WIDTH + 2;
    localparam int PROD_W      = MAG_W + MAX_W;
    localparam int CL_W        = (SUM_W > MAX_W + 1) ? SUM_W : MAX_W + 1;

    localparam logic [MAX_W-1:0] MAX_SPEED_RESET = 15'd8000;

    typedef struct packed {
        logic signed [SPEED_WIDTH-1:0] forward_speed;
        logic signed [SPEED_WIDTH-1:0] sideways_speed;
        logic signed [SPEED_WIDTH-1:0] turn_rate;
    } t_cmd;

    typedef struct packed {
        logic signed [SPEED_WIDTH-1:0] left_front_speed;
        logic signed [SPEED_WIDTH-1:0] left_rear_speed;
        logic signed [SPEED_WIDTH-1:0] right_front_speed;
        logic signed [SPEED_WIDTH-1:0] right_rear_speed;
        logic                          was_scaled;
    } t_result;

    // per-wheel divider state
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [MAX_W-1:0] num_lo;
        logic [MAX_W-1:0] quo;
        logic             neg;
    } t_div_lane;

    // request data shared by the four wheel lanes
    typedef struct packed {
        logic                                        valid;
        logic                                        scale;
        logic [MAG_W-1:0]                            divisor;
        logic [NUM_WHEELS-1:0][SPEED_WIDTH-1:0]      plain;
    } t_div_side;

    localparam logic signed [CL_W-1:0] SPEED_LIM =
        {{(CL_W - SPEED_WIDTH + 1){1'b0}}, {(SPEED_WIDTH - 1){1'b1}}};

    function automatic logic [SPEED_WIDTH-1:0] sat_speed(input logic signed [CL_W-1:0] v);
        logic signed [CL_W-1:0] r;
        r = v;
        if (v > SPEED_LIM) begin
            r = SPEED_LIM;
        end else if (v < -SPEED_LIM) begin
            r = -SPEED_LIM;
        end
        return r[SPEED_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/mwm_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwm_mixer: wheel mixing, peak search and numerator forming
// Three registered stages that feed the divider cell chain.
// ----------------------------------------------------------------------------
module mwm_mixer (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_valid,
    input  mwm_pkg::t_cmd                                  i_cmd,
    input  logic [mwm_pkg::MAX_W-1:0]                      i_max_speed,
    output mwm_pkg::t_div_side                             o_side,
    output mwm_pkg::t_div_lane [mwm_pkg::NUM_WHEELS-1:0]   o_lane
);
    import mwm_pkg::*;

    // stage 1: wheel sums
    logic                    r_v1;
    logic signed [SUM_W-1:0] r_sum [NUM_WHEELS];
    logic signed [SUM_W-1:0] n_sum [NUM_WHEELS];
    logic signed [SUM_W-1:0] vx, vy, vw;

    // stage 2: magnitudes, peak, unscaled result
    logic                    r_v2;
    logic                    r_scale2;
    logic [MAG_W-1:0]        r_lrg;
    logic [MAG_W-1:0]        r_mag   [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]   r_neg;
    logic [NUM_WHEELS-1:0][SPEED_WIDTH-1:0] r_plain2;

    logic [MAG_W-1:0]        n_mag   [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]   n_neg;
    logic [NUM_WHEELS-1:0][SPEED_WIDTH-1:0] n_plain;
    logic [SUM_W-1:0]        abs_v   [NUM_WHEELS];
    logic [MAG_W-1:0]        m01, m23, n_lrg;
    logic                    n_scale;

    // stage 3: products
    t_div_side                         r_side;
    t_div_lane [NUM_WHEELS-1:0]        r_lane;
    logic [PROD_W-1:0]                 prod [NUM_WHEELS];

    always_comb begin
        vx = SUM_W'(i_cmd.forward_speed);
        vy = SUM_W'(i_cmd.sideways_speed);
        vw = SUM_W'(i_cmd.turn_rate);
        n_sum[0] = vx + vy + vw;
        n_sum[1] = vx - vy + vw;
        n_sum[2] = vx - vy - vw;
        n_sum[3] = vx + vy - vw;
    end

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            n_neg[i]   = r_sum[i][SUM_W-1];
            abs_v[i]   = n_neg[i] ? -r_sum[i] : r_sum[i];
            n_mag[i]   = abs_v[i][MAG_W-1:0];
            n_plain[i] = sat_speed(CL_W'(r_sum[i]));
        end
        m01     = (n_mag[0] > n_mag[1]) ? n_mag[0] : n_mag[1];
        m23     = (n_mag[2] > n_mag[3]) ? n_mag[2] : n_mag[3];
        n_lrg   = (m01 > m23) ? m01 : m23;
        n_scale = CL_W'(n_lrg) > CL_W'(i_max_speed);
    end

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            prod[i] = PROD_W'(r_mag[i]) * PROD_W'(i_max_speed);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_side.valid <= 1'b0;
        end else begin
            r_v1         <= i_valid;
            r_v2         <= r_v1;
            r_side.valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum    <= n_sum;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_plain2 <= n_plain;
        r_lrg    <= n_lrg;
        r_scale2 <= n_scale;

        r_side.scale   <= r_scale2;
        r_side.divisor <= r_lrg;
        r_side.plain   <= r_plain2;
        // product < divisor * 2^MAX_W when scaling, so the top part starts below it
        for (int i = 0; i < NUM_WHEELS; i++) begin
            r_lane[i].rem    <= prod[i][PROD_W-1:MAX_W];
            r_lane[i].num_lo <= prod[i][MAX_W-1:0];
            r_lane[i].quo    <= '0;
            r_lane[i].neg    <= r_neg[i];
        end
    end

    assign o_side = r_side;
    assign o_lane = r_lane;

endmodule

// ===== rtl/mwm_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwm_div_cell: one quotient bit of the restoring divider, four lanes wide
// Brings down the next numerator bit, compares against the divisor, passes on.
// ----------------------------------------------------------------------------
module mwm_div_cell (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  mwm_pkg::t_div_side                             i_side,
    input  mwm_pkg::t_div_lane [mwm_pkg::NUM_WHEELS-1:0]   i_lane,
    output mwm_pkg::t_div_side                             o_side,
    output mwm_pkg::t_div_lane [mwm_pkg::NUM_WHEELS-1:0]   o_lane
);
    import mwm_pkg::*;

    t_div_side                  r_side;
    t_div_lane [NUM_WHEELS-1:0] r_lane;
    t_div_lane [NUM_WHEELS-1:0] n_lane;
    logic [MAG_W:0]             trial [NUM_WHEELS];
    logic [MAG_W:0]             diff  [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]      ge;

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            trial[i] = {i_lane[i].rem, i_lane[i].num_lo[MAX_W-1]};
            diff[i]  = trial[i] - {1'b0, i_side.divisor};
            ge[i]    = trial[i] >= {1'b0, i_side.divisor};
            n_lane[i].rem    = ge[i] ? diff[i][MAG_W-1:0] : trial[i][MAG_W-1:0];
            n_lane[i].num_lo = {i_lane[i].num_lo[MAX_W-2:0], 1'b0};
            n_lane[i].quo    = {i_lane[i].quo[MAX_W-2:0], ge[i]};
            n_lane[i].neg    = i_lane[i].neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else begin
            r_side.valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side.scale   <= i_side.scale;
        r_side.divisor <= i_side.divisor;
        r_side.plain   <= i_side.plain;
        r_lane         <= n_lane;
    end

    assign o_side = r_side;
    assign o_lane = r_lane;

endmodule

// ===== rtl/mecanum_wheel_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer: mecanum inverse kinematics with proportional limiting
// Mixes vx/vy/vw into four wheel speeds and rescales them when the peak
// exceeds the configured maximum.
// ----------------------------------------------------------------------------
// A request is taken on any cycle with start high; busy is always low, so one
// request per clock is accepted. Each request produces exactly one result,
// shown for one cycle with o_done, after the three mixer stages (mixing,
// peak search and the scaling multiply), the fifteen divider cells of the
// chain (one quotient bit per cell) and the output register.
// Results cannot be held off; the receiver must take each on its strobe.
// Write max_wheel_speed only while no request is in flight.
module mecanum_wheel_mixer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  mwm_pkg::t_cmd               i_cmd,
    input  logic                        i_cfg_we,
    input  logic [mwm_pkg::MAX_W-1:0]   i_cfg_wdata,
    output logic                        o_done,
    output mwm_pkg::t_result            o_result
);
    import mwm_pkg::*;

    logic [MAX_W-1:0]            r_max_speed;
    logic                        r_done;
    t_result                     r_result;
    t_result                     n_result;

    t_div_side                   side [MAX_W+1];
    t_div_lane [NUM_WHEELS-1:0]  lane [MAX_W+1];

    logic [NUM_WHEELS-1:0][SPEED_WIDTH-1:0] wheel;
    logic [CL_W-1:0]             q_ext [NUM_WHEELS];
    logic [CL_W-1:0]             q_sgn [NUM_WHEELS];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= MAX_SPEED_RESET;
        end else if (i_cfg_we) begin
            r_max_speed <= i_cfg_wdata;
        end
    end

    mwm_mixer u_mixer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start & ~busy),
        .i_cmd       (i_cmd),
        .i_max_speed (r_max_speed),
        .o_side      (side[0]),
        .o_lane      (lane[0])
    );

    for (genvar g = 0; g < MAX_W; g++) begin : g_cell
        mwm_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_side  (side[g]),
            .i_lane  (lane[g]),
            .o_side  (side[g+1]),
            .o_lane  (lane[g+1])
        );
    end

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            q_ext[i] = CL_W'(lane[MAX_W][i].quo);
            q_sgn[i] = lane[MAX_W][i].neg ? -q_ext[i] : q_ext[i];
            wheel[i] = side[MAX_W].scale ? sat_speed(signed'(q_sgn[i]))
                                         : side[MAX_W].plain[i];
        end
        n_result.left_front_speed  = wheel[0];
        n_result.left_rear_speed   = wheel[1];
        n_result.right_front_speed = wheel[2];
        n_result.right_rear_speed  = wheel[3];
        n_result.was_scaled        = side[MAX_W].scale;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= side[MAX_W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== tb/mecanum_wheel_mixer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_tb: self-checking bench for the mecanum wheel mixer
// A short directed table (extremes, zero maximum, limit boundaries) and then
// random command phases under several max_wheel_speed settings. Every
// accepted request is predicted from the mixing and limiting rule or typed in
// its table row, and checked field by field against the one-cycle o_done result.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_tb;
    import mwm_pkg::*;

    typedef enum logic [1:0] {
        ROW_SET_MAX,
        ROW_PREDICT,
        ROW_TYPED
    } t_row_kind;

    // directed row: a = new maximum for ROW_SET_MAX, else a/b/c = vx/vy/vw
    typedef struct packed {
        t_row_kind kind;
        int        a;
        int        b;
        int        c;
        int        w0;
        int        w1;
        int        w2;
        int        w3;
        logic      scaled;
    } t_row;

    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 50;
    localparam int TAIL_CYCLES = 30;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_cmd                 i_cmd;
    logic                 i_cfg_we;
    logic [MAX_W-1:0]     i_cfg_wdata;
    logic                 o_done;
    t_result              o_result;

    t_result              pending_wheels[$];
    t_row                 dir_tab[$];
    logic [MAX_W-1:0]     cur_max;
    bit                   idle_on;
    int                   mismatches;

    mecanum_wheel_mixer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic note_error(input string msg);
        $display("tb: mismatch: %s", msg);
        mismatches++;
    endtask

    // mix vx/vy/vw into four wheels, scale them down when the peak exceeds lim
    function automatic t_result mix_and_limit(input t_cmd c, input logic [MAX_W-1:0] lim);
        longint  w [NUM_WHEELS];
        longint  vx, vy, vw, peak, mag, q, bound;
        bit      scale;
        int      i;
        t_result r;
        vx = longint'(c.forward_speed);
        vy = longint'(c.sideways_speed);
        vw = longint'(c.turn_rate);
        w[0] = vx + vy + vw;
        w[1] = vx - vy + vw;
        w[2] = vx - vy - vw;
        w[3] = vx + vy - vw;
        bound = (longint'(1) << (SPEED_WIDTH - 1)) - 1;
        peak = 0;
        for (i = 0; i < NUM_WHEELS; i++) begin
            mag = (w[i] < 0) ? -w[i] : w[i];
            if (mag > peak) begin
                peak = mag;
            end
        end
        scale = peak > longint'(lim);
        for (i = 0; i < NUM_WHEELS; i++) begin
            if (scale) begin
                mag = (w[i] < 0) ? -w[i] : w[i];
                q = (mag * longint'(lim)) / peak;
                w[i] = (w[i] < 0) ? -q : q;
            end
            if (w[i] > bound) begin
                w[i] = bound;
            end else if (w[i] < -bound) begin
                w[i] = -bound;
            end
        end
        r.left_front_speed  = w[0][SPEED_WIDTH-1:0];
        r.left_rear_speed   = w[1][SPEED_WIDTH-1:0];
        r.right_front_speed = w[2][SPEED_WIDTH-1:0];
        r.right_rear_speed  = w[3][SPEED_WIDTH-1:0];
        r.was_scaled        = scale;
        return r;
    endfunction

    function automatic logic signed [SPEED_WIDTH-1:0] rand_speed(input int mode);
        logic signed [SPEED_WIDTH-1:0] v;
        case (mode)
            0: v = SPEED_WIDTH'($urandom);
            1: v = SPEED_WIDTH'($urandom_range(0, 2000)) - SPEED_WIDTH'(1000);
            2: begin
                case ($urandom_range(0, 5))
                    0: v = {1'b1, {(SPEED_WIDTH - 1){1'b0}}};
                    1: v = {1'b1, {(SPEED_WIDTH - 2){1'b0}}, 1'b1};
                    2: v = '1;
                    3: v = '0;
                    4: v = SPEED_WIDTH'(1);
                    default: v = {1'b0, {(SPEED_WIDTH - 1){1'b1}}};
                endcase
            end
            default: v = SPEED_WIDTH'($urandom_range(0, 12000)) - SPEED_WIDTH'(6000);
        endcase
        return v;
    endfunction

    // present one request, hold it until taken, then queue its expected wheels
    task automatic issue(input t_cmd c, input bit typed, input t_result want);
        while (idle_on && $urandom_range(0, 99) < 33) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do begin
            @(posedge i_clk);
        end while (busy);
        pending_wheels.push_back(typed ? want : mix_and_limit(c, cur_max));
    endtask

    task automatic write_max(input logic [MAX_W-1:0] m);
        start <= 1'b0;
        while (pending_wheels.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_max = m;
    endtask

    // result checker: o_done is sampled at the edge that ends its cycle
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_wheels.size() == 0) begin
                note_error("result with no request pending");
            end else begin
                want = pending_wheels.pop_front();
                if (o_result.left_front_speed !== want.left_front_speed) begin
                    note_error($sformatf("left_front_speed got %0d want %0d",
                        o_result.left_front_speed, want.left_front_speed));
                end
                if (o_result.left_rear_speed !== want.left_rear_speed) begin
                    note_error($sformatf("left_rear_speed got %0d want %0d",
                        o_result.left_rear_speed, want.left_rear_speed));
                end
                if (o_result.right_front_speed !== want.right_front_speed) begin
                    note_error($sformatf("right_front_speed got %0d want %0d",
                        o_result.right_front_speed, want.right_front_speed));
                end
                if (o_result.right_rear_speed !== want.right_rear_speed) begin
                    note_error($sformatf("right_rear_speed got %0d want %0d",
                        o_result.right_rear_speed, want.right_rear_speed));
                end
                if (o_result.was_scaled !== want.was_scaled) begin
                    note_error($sformatf("was_scaled got %0b want %0b",
                        o_result.was_scaled, want.was_scaled));
                end
            end
        end
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_cmd    c;
        t_result e;
        t_row    r;
        int      p, n, mode;
        logic [MAX_W-1:0] m;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_cmd       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        cur_max     = MAX_SPEED_RESET;
        idle_on     = 1'b1;
        mismatches  = 0;

        // reset maximum is 8000
        dir_tab.push_back('{ROW_TYPED, 0, 0, 0, 0, 0, 0, 0, 1'b0});
        dir_tab.push_back('{ROW_TYPED, 100, 0, 0, 100, 100, 100, 100, 1'b0});
        dir_tab.push_back('{ROW_TYPED, 8000, 0, 0, 8000, 8000, 8000, 8000, 1'b0});
        dir_tab.push_back('{ROW_TYPED, 8001, 0, 0, 8000, 8000, 8000, 8000, 1'b1});
        dir_tab.push_back('{ROW_TYPED, 0, 500, 0, 500, -500, -500, 500, 1'b0});
        dir_tab.push_back('{ROW_TYPED, 0, 0, -300, -300, -300, 300, 300, 1'b0});
        dir_tab.push_back('{ROW_PREDICT, 32767, 32767, 32767, 0, 0, 0, 0, 1'b0});
        dir_tab.push_back('{ROW_PREDICT, -32768, -32768, -32768, 0, 0, 0, 0, 1'b0});
        dir_tab.push_back('{ROW_PREDICT, 32767, -32768, 0, 0, 0, 0, 0, 1'b0});
        // zero maximum: everything nonzero collapses to 0
        dir_tab.push_back('{ROW_SET_MAX, 0, 0, 0, 0, 0, 0, 0, 1'b0});
        dir_tab.push_back('{ROW_TYPED, 1, 0, 0, 0, 0, 0, 0, 1'b1});
        dir_tab.push_back('{ROW_TYPED, 0, 0, 0, 0, 0, 0, 0, 1'b0});
        dir_tab.push_back('{ROW_TYPED, -32768, -32768, -32768, 0, 0, 0, 0, 1'b1});
        // widest maximum
        dir_tab.push_back('{ROW_SET_MAX, 32767, 0, 0, 0, 0, 0, 0, 1'b0});
        dir_tab.push_back('{ROW_TYPED, 32767, 0, 0, 32767, 32767, 32767, 32767, 1'b0});
        dir_tab.push_back('{ROW_TYPED, -32768, 0, 0, -32767, -32767, -32767, -32767, 1'b1});
        dir_tab.push_back('{ROW_PREDICT, 32767, 32767, 32767, 0, 0, 0, 0, 1'b0});
        dir_tab.push_back('{ROW_PREDICT, -32768, 32767, -32768, 0, 0, 0, 0, 1'b0});
        // smallest nonzero maximum
        dir_tab.push_back('{ROW_SET_MAX, 1, 0, 0, 0, 0, 0, 0, 1'b0});
        dir_tab.push_back('{ROW_TYPED, 1, 0, 0, 1, 1, 1, 1, 1'b0});
        dir_tab.push_back('{ROW_TYPED, 2, 0, 0, 1, 1, 1, 1, 1'b1});
        dir_tab.push_back('{ROW_PREDICT, 3, 1, 1, 0, 0, 0, 0, 1'b0});
        dir_tab.push_back('{ROW_PREDICT, 32767, -32768, 32767, 0, 0, 0, 0, 1'b0});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            r = dir_tab[k];
            if (r.kind == ROW_SET_MAX) begin
                write_max(r.a[MAX_W-1:0]);
            end else begin
                c.forward_speed     = r.a[SPEED_WIDTH-1:0];
                c.sideways_speed    = r.b[SPEED_WIDTH-1:0];
                c.turn_rate         = r.c[SPEED_WIDTH-1:0];
                e.left_front_speed  = r.w0[SPEED_WIDTH-1:0];
                e.left_rear_speed   = r.w1[SPEED_WIDTH-1:0];
                e.right_front_speed = r.w2[SPEED_WIDTH-1:0];
                e.right_rear_speed  = r.w3[SPEED_WIDTH-1:0];
                e.was_scaled        = r.scaled;
                issue(c, r.kind == ROW_TYPED, e);
            end
        end

        for (p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(0, 5))
                0: m = '0;
                1: m = MAX_W'(1);
                2: m = '1;
                3: m = MAX_W'($urandom);
                4: m = MAX_W'($urandom_range(1, 500));
                default: m = MAX_W'($urandom_range(5000, 20000));
            endcase
            if (p == RAND_PHASES - 1) begin
                m = MAX_SPEED_RESET;
            end
            write_max(m);
            // two back-to-back phases with the sender never pausing
            idle_on = !(p == 3 || p == 4);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                mode = $urandom_range(0, 3);
                c.forward_speed  = rand_speed(mode);
                c.sideways_speed = rand_speed($urandom_range(0, 1) ? mode : $urandom_range(0, 3));
                c.turn_rate      = rand_speed($urandom_range(0, 1) ? mode : $urandom_range(0, 3));
                issue(c, 1'b0, e);
            end
        end
        start <= 1'b0;

        while (pending_wheels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
